### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertions clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pwlc_pkg.sv
// ----------------------------------------------------------------------------
// pwlc_pkg
// Types and constants shared by the piecewise linear color map modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwlc_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int FRAC_BITS    = 16;
	localparam int COORD_W      = 17;
	localparam int INDEX_W      = 12;
	localparam int COUNT_W      = 13;
	localparam int PROD_W       = COORD_W + COUNT_W;
	localparam int QUOT_W       = 33;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [COUNT_W-1:0] COLOR_COUNT_RESET = 13'd256;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam logic [7:0]  SAT8_MAX  = 8'hFF;
	localparam logic [15:0] SAT16_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [1:0]         channel;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [INDEX_W-1:0] entry_index;
	} item_t;

	typedef struct packed {
		logic [7:0]  value_8;
		logic [15:0] value_16;
		logic [1:0]  status;
	} result_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_QUERY,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               chan_ok;
		logic [1:0]         channel;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [INDEX_W-1:0] entry_index;
	} qent_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_PROD,
		ST_CMP,
		ST_DIFF,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_END,
		ST_PUSH
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/pwlc_front.sv
// ----------------------------------------------------------------------------
// pwlc_front
// Accepts input transactions, decodes the command and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pwlc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire pwlc_pkg::item_t item,
	output logic                 q_valid,
	output pwlc_pkg::qent_t      q_entry,
	input  wire logic            q_pop
);
	import pwlc_pkg::*;

	localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);

	qent_t          cls;
	qent_t          entries_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0] count_q;
	logic           push;

	// decode command and channel range
	always_comb begin
		cls.channel     = item.channel;
		cls.point_x     = item.point_x;
		cls.point_y     = item.point_y;
		cls.entry_index = item.entry_index;
		cls.chan_ok     = (item.channel < 2'(NUM_CHANNELS));
		case (item.cmd)
			CMD_CLEAR:  cls.op = OP_CLEAR;
			CMD_APPEND: cls.op = OP_APPEND;
			CMD_QUERY:  cls.op = OP_QUERY;
			default:    cls.op = OP_NOP;
		endcase
	end

	assign item_stall = (count_q == CNW'(QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != '0);
	assign q_entry    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			end
			if (q_pop) begin
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			end
			if (push && !q_pop) begin
				count_q <= CNW'(count_q + 1'b1);
			end else if (!push && q_pop) begin
				count_q <= CNW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cls;
		end
	end

	`ASSERT_IMPL(a_pop_nonempty, q_pop, count_q != '0, "pop from empty queue")
	`ASSERT_IMPL(a_count_range, 1'b1, count_q <= CNW'(QUEUE_DEPTH), "queue count overflow")
	`ASSERT_NEXT(a_push_grows, push && !q_pop, count_q == CNW'($past(count_q) + 1'b1),
		"queue count did not advance on push")

endmodule

`default_nettype wire

### hw/rtl/pwlc_back.sv
// ----------------------------------------------------------------------------
// pwlc_back
// Breakpoint store, search and interpolation sequencer with output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pwlc_back #(
	parameter int MAX_POINTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [pwlc_pkg::COUNT_W-1:0]  color_count,
	input  wire logic                          q_valid,
	input  wire pwlc_pkg::qent_t               q_entry,
	output logic                               q_pop,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output pwlc_pkg::result_t                  result
);
	import pwlc_pkg::*;

	localparam int CW      = $clog2(MAX_POINTS + 1);
	localparam int DEPTH   = NUM_CHANNELS * MAX_POINTS;
	localparam int AW      = $clog2(DEPTH);
	localparam int ENTRY_W = 2 * COORD_W;
	localparam int NUM_W   = COORD_W + PROD_W;
	localparam int SUM_W   = NUM_W + 1;
	localparam int DIVD_W  = SUM_W + FRAC_BITS;
	localparam int SW      = $clog2(QUOT_W + 1);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_q, ent_q;
	logic [CW-1:0]      counts_q [NUM_CHANNELS];
	logic [CW-1:0]      k_q, n_q, head_n;
	qent_t              cur_q;
	state_t             state_q, state_d;

	logic [PROD_W-1:0]  prod_q, prev_prod_q, d_q, t_q, dmt_q, target_w;
	logic [COORD_W-1:0] prev_y_q;
	logic [NUM_W-1:0]   p1_q, p2_q;
	logic [SUM_W-1:0]   num_q;
	logic [DIVD_W-1:0]  a8, a16;
	logic [PROD_W-1:0]  rem8_q, rem16_q;
	logic [QUOT_W-1:0]  lo8_q, lo16_q;
	logic [SW-1:0]      step_q;
	logic [PROD_W:0]    r8, r16;
	logic               ge8, ge16;
	logic [COUNT_W-1:0] cnt;
	logic [QUOT_W-FRAC_BITS-1:0] q8, q16;
	logic [1:0]         idle_status;

	result_t            res_q, result_q;
	logic               result_valid_q;

	logic               rd_en, wr_en, push_res, below, last, append_ok;
	logic [AW-1:0]      rd_addr, wr_addr;

	function automatic result_t clamp_res(input logic [COORD_W-1:0] y);
		logic [COORD_W+7:0]  s8;
		logic [COORD_W+15:0] s16;
		result_t             r;
		s8  = {y, 8'b0} - {8'b0, y};
		s16 = {y, 16'b0} - {16'b0, y};
		r.value_8  = (s8[COORD_W+7:16] > 9'(SAT8_MAX)) ? SAT8_MAX : s8[23:16];
		r.value_16 = (s16[COORD_W+15:16] > 17'(SAT16_MAX)) ? SAT16_MAX : s16[31:16];
		r.status   = STATUS_OK;
		return r;
	endfunction

	assign cnt      = (color_count == '0) ? COUNT_W'(1) : color_count;
	assign target_w = {{(PROD_W-INDEX_W-FRAC_BITS){1'b0}}, cur_q.entry_index,
		{FRAC_BITS{1'b0}}};
	assign head_n    = q_entry.chan_ok ? counts_q[q_entry.channel] : '0;
	assign append_ok = q_entry.chan_ok && (head_n < CW'(MAX_POINTS));
	assign below     = prod_q < target_w;
	assign last      = (k_q + CW'(1)) == n_q;

	assign idle_status = (q_entry.op == OP_APPEND && !append_ok) ? STATUS_FULL
		: (q_entry.op == OP_QUERY && (!q_entry.chan_ok || head_n == '0)) ? STATUS_EMPTY
		: STATUS_OK;

	assign a8  = (DIVD_W'(num_q) << 8) - DIVD_W'(num_q);
	assign a16 = (DIVD_W'(num_q) << 16) - DIVD_W'(num_q);
	assign r8  = {rem8_q, lo8_q[QUOT_W-1]};
	assign r16 = {rem16_q, lo16_q[QUOT_W-1]};
	assign ge8  = r8 >= {1'b0, d_q};
	assign ge16 = r16 >= {1'b0, d_q};
	assign q8  = lo8_q[QUOT_W-1:FRAC_BITS];
	assign q16 = lo16_q[QUOT_W-1:FRAC_BITS];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_entry.op == OP_QUERY && q_entry.chan_ok && head_n != '0) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_READ: state_d = ST_PROD;
			ST_PROD: state_d = ST_CMP;
			ST_CMP: begin
				if (below) begin
					state_d = last ? ST_PUSH : ST_PROD;
				end else begin
					state_d = (k_q == '0) ? ST_PUSH : ST_DIFF;
				end
			end
			ST_DIFF:     state_d = ST_MUL_LO;
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_SUM;
			ST_SUM:      state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV:      state_d = (step_q == SW'(QUOT_W - 1)) ? ST_DIV_END : ST_DIV;
			ST_DIV_END:  state_d = ST_PUSH;
			ST_PUSH: begin
				if (!result_valid_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		push_res = 1'b0;
		rd_addr  = AW'(int'(cur_q.channel) * MAX_POINTS + int'(k_q));
		wr_addr  = AW'(int'(q_entry.channel) * MAX_POINTS + int'(head_n));
		case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
				wr_en = q_valid && q_entry.op == OP_APPEND && append_ok;
			end
			ST_READ: rd_en = 1'b1;
			ST_CMP: begin
				rd_en   = below && !last;
				rd_addr = AW'(int'(cur_q.channel) * MAX_POINTS + int'(k_q) + 1);
			end
			ST_PUSH: push_res = !result_valid_q || !result_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (push_res) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (q_entry.op)
					OP_CLEAR: begin
						for (int i = 0; i < NUM_CHANNELS; i++) begin
							counts_q[i] <= '0;
						end
					end
					OP_APPEND: begin
						if (append_ok) begin
							counts_q[q_entry.channel] <= CW'(head_n + 1'b1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {q_entry.point_x, q_entry.point_y};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (push_res) begin
			result_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				cur_q <= q_entry;
				n_q   <= head_n;
				k_q   <= '0;
				res_q <= {8'b0, 16'b0, idle_status};
			end
			ST_PROD: begin
				prod_q <= PROD_W'(rd_q[ENTRY_W-1:COORD_W]) * PROD_W'(cnt);
				ent_q  <= rd_q;
			end
			ST_CMP: begin
				if (below) begin
					prev_prod_q <= prod_q;
					prev_y_q    <= ent_q[COORD_W-1:0];
					k_q         <= CW'(k_q + 1'b1);
					if (last) begin
						res_q <= clamp_res(ent_q[COORD_W-1:0]);
					end
				end else if (k_q == '0) begin
					res_q <= clamp_res(ent_q[COORD_W-1:0]);
				end
			end
			ST_DIFF: begin
				d_q   <= prod_q - prev_prod_q;
				t_q   <= target_w - prev_prod_q;
				dmt_q <= prod_q - target_w;
			end
			ST_MUL_LO: p1_q  <= NUM_W'(prev_y_q) * NUM_W'(dmt_q);
			ST_MUL_HI: p2_q  <= NUM_W'(ent_q[COORD_W-1:0]) * NUM_W'(t_q);
			ST_SUM:    num_q <= SUM_W'(p1_q) + SUM_W'(p2_q);
			ST_DIV_INIT: begin
				// high part is below the divisor since the quotient fits QUOT_W bits
				rem8_q  <= a8[QUOT_W+PROD_W-1:QUOT_W];
				rem16_q <= a16[QUOT_W+PROD_W-1:QUOT_W];
				lo8_q   <= a8[QUOT_W-1:0];
				lo16_q  <= a16[QUOT_W-1:0];
				step_q  <= '0;
			end
			ST_DIV: begin
				rem8_q  <= ge8 ? PROD_W'(r8 - {1'b0, d_q}) : r8[PROD_W-1:0];
				rem16_q <= ge16 ? PROD_W'(r16 - {1'b0, d_q}) : r16[PROD_W-1:0];
				lo8_q   <= {lo8_q[QUOT_W-2:0], ge8};
				lo16_q  <= {lo16_q[QUOT_W-2:0], ge16};
				step_q  <= SW'(step_q + 1'b1);
			end
			ST_DIV_END: begin
				res_q.value_8  <= (q8 > (QUOT_W-FRAC_BITS)'(SAT8_MAX)) ? SAT8_MAX : q8[7:0];
				res_q.value_16 <= (q16 > (QUOT_W-FRAC_BITS)'(SAT16_MAX)) ? SAT16_MAX
					: q16[15:0];
				res_q.status   <= STATUS_OK;
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_IMPL(a_rem_below_div, state_q == ST_DIV, rem8_q < d_q && rem16_q < d_q,
		"divider remainder not below divisor")
	`ASSERT_IMPL(a_count_limit, 1'b1, counts_q[0] <= CW'(MAX_POINTS)
		&& counts_q[1] <= CW'(MAX_POINTS) && counts_q[2] <= CW'(MAX_POINTS),
		"channel point count over limit")
	`ASSERT_NEXT(a_push_shows, push_res, result_valid_q, "pushed result not presented")

endmodule

`default_nettype wire

### hw/rtl/piecewise_linear_colormap.sv
// ----------------------------------------------------------------------------
// piecewise_linear_colormap
// Per-channel breakpoint lists with piecewise linear lookup for a color map.
// ----------------------------------------------------------------------------
// Each transaction clears all lists, appends a breakpoint to one channel or
// queries a channel at map entry entry_index, and returns exactly one result.
// A front stage decodes and queues up to two transactions so the input keeps
// flowing while the back sequencer works; the output register lets the next
// transaction start while a result waits. Clear, append and unused commands
// go through the idle and push states of the back sequencer. A query also
// takes one store read and one position multiply per breakpoint searched,
// and when it lands between two points then the differences step, two
// registered multiplies, a sum, a divider load, a 33-step radix-2 divider
// that forms the 8-bit and 16-bit answers in parallel, and a final saturate.
// A stalled result holds the sequencer in its push state. color_count is
// written through cfg_data and is always ready; a value of zero acts as one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_colormap #(
	parameter int MAX_POINTS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input transactions
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire pwlc_pkg::item_t              item,
	// result transactions
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output pwlc_pkg::result_t                 result,
	// color_count register write
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [pwlc_pkg::COUNT_W-1:0] cfg_data
);
	import pwlc_pkg::*;

	logic [COUNT_W-1:0] color_count_q;
	logic               q_valid, q_pop;
	qent_t              q_entry;

	// the register takes every write directly, so never hold off the writer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q <= COLOR_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			color_count_q <= cfg_data;
		end
	end

	// decode and buffer incoming transactions
	pwlc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop)
	);

	// store, search, interpolate and drive the result register
	pwlc_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.color_count  (color_count_q),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
